[hdl/bpc_pkg.sv]
// Package with the types and constants shared by the button press classifier.
`default_nettype none
package bpc_pkg;

  localparam int TIME_MAX_DEF  = 2147483647;
  localparam int COUNT_MAX_DEF = 255;

  localparam int TS_W  = 31;
  localparam int TPS_W = 29;
  localparam int RC_W  = 8;

  typedef enum logic [1:0] {
    FN_START   = 2'd0,
    FN_PRESS   = 2'd1,
    FN_RELEASE = 2'd2,
    FN_TICK    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_UNKNOWN  = 3'd0,
    ST_IDLE     = 3'd1,
    ST_WAIT_REL = 3'd2,
    ST_WAITING  = 3'd3,
    ST_REPORT   = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    TY_UNKNOWN = 2'd0,
    TY_SHORT   = 2'd1,
    TY_LONG    = 2'd2,
    TY_FIVE    = 2'd3
  } ptype_t;

  typedef struct packed {
    func_t            func;
    logic [TS_W-1:0]  timestamp;
  } event_t;

  typedef struct packed {
    logic             accepted;
    state_t           machine_state;
    logic             report_fired;
    logic             report_ready;
    ptype_t           reported_type;
    logic [RC_W-1:0]  reported_count;
    logic [TS_W-1:0]  last_release_time;
  } result_t;

endpackage
`default_nettype wire

[hdl/bpc_core.sv]
// Classifier state machine: holds the press state and works out one result per event.
`default_nettype none
module bpc_core #(
  parameter int TIME_MAX  = bpc_pkg::TIME_MAX_DEF,
  parameter int COUNT_MAX = bpc_pkg::COUNT_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire bpc_pkg::event_t            ev,
  input  wire logic [bpc_pkg::TPS_W-1:0]  ticks_per_second,
  output bpc_pkg::result_t                res
);
  import bpc_pkg::*;

  localparam int CNT_W = $clog2(COUNT_MAX + 1);
  localparam int LEN_W = TS_W + 2;
  localparam logic [TS_W-1:0]  TMAX = TS_W'(TIME_MAX);
  localparam logic [CNT_W-1:0] CMAX = CNT_W'(COUNT_MAX);

  state_t            state, state_next;
  logic [CNT_W-1:0]  pending_count, pending_count_next;
  ptype_t            pending_type, pending_type_next;
  logic [RC_W-1:0]   latched_count, latched_count_next;
  ptype_t            latched_type, latched_type_next;
  logic [TS_W-1:0]   press_stamp, press_stamp_next;
  logic [TS_W-1:0]   release_stamp, release_stamp_next;

  logic [TS_W-1:0]   ts;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  thr_long;
  logic [LEN_W-1:0]  thr_five;
  ptype_t            cls;
  logic [CNT_W-1:0]  count_inc;
  logic              acc;
  logic              rep_req;
  ptype_t            rep_type;
  logic [CNT_W-1:0]  rep_count;
  logic              rep_latch;
  logic              rep_clear;

  always_comb begin
    ts = (ev.timestamp > TMAX) ? TMAX : ev.timestamp;
    if (press_stamp < ts) begin
      len = LEN_W'(ts) - LEN_W'(press_stamp);
    end else begin
      len = LEN_W'(TMAX) - LEN_W'(press_stamp) + LEN_W'(ts);
    end
    thr_long = LEN_W'(ticks_per_second);
    thr_five = (LEN_W'(ticks_per_second) << 2) + LEN_W'(ticks_per_second);
    if (len >= thr_five) begin
      cls = TY_FIVE;
    end else if (len >= thr_long) begin
      cls = TY_LONG;
    end else begin
      cls = TY_SHORT;
    end
    count_inc = (pending_count < CMAX) ? pending_count + CNT_W'(1) : CMAX;
  end

  // Decode what the event asks for in the present state.
  always_comb begin
    acc       = 1'b0;
    rep_req   = 1'b0;
    rep_type  = pending_type;
    rep_count = pending_count;
    case (ev.func)
      FN_START: begin
        acc = 1'b1;
      end
      FN_PRESS: begin
        acc = (state == ST_IDLE) || (state == ST_WAITING);
      end
      FN_RELEASE: begin
        acc       = (state == ST_WAIT_REL);
        rep_req   = (state == ST_WAIT_REL) && (cls == TY_FIVE);
        rep_type  = cls;
        rep_count = count_inc;
      end
      FN_TICK: begin
        acc     = (state == ST_WAITING) || (state == ST_REPORT);
        rep_req = (state == ST_WAITING);
      end
      default: begin
        acc = 1'b0;
      end
    endcase
    rep_latch = rep_req && (latched_type != rep_type) && (latched_type == TY_UNKNOWN);
    rep_clear = rep_req && (latched_type != rep_type) && (latched_type != TY_UNKNOWN);
  end

  always_comb begin
    state_next = state;
    case (ev.func)
      FN_START:   state_next = ST_IDLE;
      FN_PRESS:   state_next = acc ? ST_WAIT_REL : ST_IDLE;
      FN_RELEASE: state_next = !acc ? ST_IDLE : (cls == TY_FIVE) ? ST_REPORT : ST_WAITING;
      FN_TICK: begin
        if (state == ST_WAITING) begin
          state_next = ST_REPORT;
        end else if (state != ST_REPORT) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = state;
    endcase
    if (rep_clear) begin
      state_next = ST_IDLE;
    end
  end

  always_comb begin
    pending_count_next = pending_count;
    pending_type_next  = pending_type;
    latched_count_next = latched_count;
    latched_type_next  = latched_type;
    press_stamp_next   = press_stamp;
    release_stamp_next = release_stamp;
    if (ev.func == FN_PRESS && acc) begin
      press_stamp_next  = ts;
      pending_type_next = TY_UNKNOWN;
    end
    if (ev.func == FN_RELEASE && acc) begin
      release_stamp_next = ts;
      pending_type_next  = cls;
      pending_count_next = count_inc;
    end
    if (rep_latch) begin
      latched_type_next  = rep_type;
      latched_count_next = RC_W'(rep_count);
    end
    if (ev.func == FN_START || (ev.func == FN_PRESS && !acc) || rep_clear) begin
      pending_count_next = '0;
      pending_type_next  = TY_UNKNOWN;
      latched_count_next = '0;
      latched_type_next  = TY_UNKNOWN;
      press_stamp_next   = '0;
      release_stamp_next = '0;
    end
    res.accepted          = acc;
    res.machine_state     = state_next;
    res.report_fired      = rep_latch;
    res.report_ready      = (state_next == ST_REPORT);
    res.reported_type     = latched_type_next;
    res.reported_count    = latched_count_next;
    res.last_release_time = release_stamp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_UNKNOWN;
      pending_count <= '0;
      pending_type  <= TY_UNKNOWN;
      latched_count <= '0;
      latched_type  <= TY_UNKNOWN;
      press_stamp   <= '0;
      release_stamp <= '0;
    end else if (take) begin
      state         <= state_next;
      pending_count <= pending_count_next;
      pending_type  <= pending_type_next;
      latched_count <= latched_count_next;
      latched_type  <= latched_type_next;
      press_stamp   <= press_stamp_next;
      release_stamp <= release_stamp_next;
    end
  end

endmodule
`default_nettype wire

[hdl/button_press_classifier.sv]
// Top level of the button press classifier with its output register and skid stage.
// Events (start, press, release, report tick, each with a timestamp) enter on the
// ev channel as one beat each; every event yields exactly one result beat on the
// res channel, carrying the acceptance flag, the new machine state, the report
// pulse and the latched report. Classification and state update are combinational;
// the result is registered and shown in the cycle after its event is taken unless the
// receiver stalls, and an event can be taken in every cycle while ev_stall is low.
// The single configuration register, the tick count of one second, is written through
// the cfg channel, which is always ready; it should be changed only while no event is
// in flight. Synchronous reset returns the machine to the unknown state with all counts,
// types and stamps at zero and the register at zero, and empties the output stages.
// When the receiver stalls, the result is held in the output register and one further
// result goes into the skid stage; ev_stall then rises until the skid stage drains.
`default_nettype none
module button_press_classifier #(
  parameter int TIME_MAX  = bpc_pkg::TIME_MAX_DEF,
  parameter int COUNT_MAX = bpc_pkg::COUNT_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       ev_valid,
  output logic                            ev_stall,
  input  wire bpc_pkg::event_t            ev,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output bpc_pkg::result_t                res,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bpc_pkg::TPS_W-1:0]  cfg_data
);
  import bpc_pkg::*;

  logic [TPS_W-1:0] ticks_per_second;
  logic             take;
  result_t          res_new;
  logic             skid_valid;
  result_t          skid;

  assign cfg_ready = 1'b1;
  assign ev_stall  = skid_valid;
  assign take      = ev_valid && !ev_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_second <= cfg_data;
    end
  end

  bpc_core #(
    .TIME_MAX  (TIME_MAX),
    .COUNT_MAX (COUNT_MAX)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .ev               (ev),
    .ticks_per_second (ticks_per_second),
    .res              (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res <= skid;
      end else if (take) begin
        res <= res_new;
      end
    end else if (take) begin
      skid <= res_new;
    end
  end

endmodule
`default_nettype wire
